FILE: sv/nwh_pkg.sv
package nwh_pkg;

    localparam int MAX_LEN   = 64;
    localparam int FRAC_BITS = 16;
    localparam int AW        = $clog2(MAX_LEN);
    localparam int CW        = AW + 1;
    localparam int QDEPTH    = 4;
    localparam int QAW       = $clog2(QDEPTH);

    localparam logic [29:0] STAGE_K     = 30'd759250125;
    localparam int          STAGE_SHIFT = 30;

    typedef logic signed [31:0] sample_t;
    typedef logic [CW-1:0]      count_t;
    typedef logic [AW-1:0]      addr_t;

    typedef struct packed {
        sample_t sample;
        logic    is_final;
        logic    keep;
    } qword_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD_A,
        ST_RD_B,
        ST_MUL,
        ST_WR,
        ST_OUT
    } back_state_t;

    function automatic count_t pow2_below(input count_t n);
        count_t p;
        p = count_t'(1);
        for (int i = 1; i < CW; i++)
        begin
            if (n[i])
            begin
                p = count_t'(1) << i;
            end
        end
        return p;
    endfunction

endpackage

FILE: sv/normalized_walsh_hadamard_top.sv
// Normalized fast Walsh-Hadamard transform. Send a vector as words on start
// (taken whenever busy is low); is_final ends it. Up to 64 words are kept,
// later ones are dropped and flagged. After the final word the back end runs
// log2(P) stages of P/2 butterflies on one shared unit, each one stepping
// through read A, read B, multiply and write; it then streams every stored
// word out at one per cycle on strobe, with end_of_vector on the last. Words
// of the next vector queue (four deep) while the transform runs and busy
// rises only when that queue is full. Results cannot be stalled.
module normalized_walsh_hadamard_top
    import nwh_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  sample_t sample_in,
    input  logic    is_final,
    output logic    strobe,
    output sample_t sample_out,
    output logic    end_of_vector,
    output logic [6:0] rotated_length,
    output logic    overrun
);

    logic   push, pop, empty, full, fovr, qovr;
    qword_t wword, rword;

    assign busy = full;

    nwh_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .sample_in(sample_in),
        .is_final(is_final), .q_full(full), .q_push(push), .q_word(wword),
        .overrun(fovr)
    );

    nwh_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .wdata(wword), .ovr_in(fovr),
        .pop(pop), .empty(empty), .full(full), .rdata(rword), .ovr_out(qovr)
    );

    nwh_back u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(empty), .q_word(rword), .q_ovr(qovr),
        .q_pop(pop), .valid(strobe), .sample_out(sample_out),
        .end_of_vector(end_of_vector), .rotated_length(rotated_length),
        .overrun(overrun)
    );

endmodule

FILE: sv/nwh_front.sv
module nwh_front
    import nwh_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  sample_t sample_in,
    input  logic    is_final,
    input  logic    q_full,
    output logic    q_push,
    output qword_t  q_word,
    output logic    overrun
);

    count_t cnt_reg, cnt_next;
    logic   ovr_reg, ovr_next;
    logic   keep;

    assign keep = (cnt_reg < count_t'(MAX_LEN));
    assign q_push = start && !q_full;
    assign q_word = '{sample: sample_in, is_final: is_final, keep: keep};

    always_comb
    begin
        cnt_next = cnt_reg;
        ovr_next = ovr_reg;
        if (q_push)
        begin
            if (is_final)
            begin
                cnt_next = '0;
                ovr_next = 1'b0;
            end
            else if (keep)
            begin
                cnt_next = cnt_reg + count_t'(1);
            end
            else
            begin
                ovr_next = 1'b1;
            end
        end
    end

    // overrun for the final word, including a drop of the final word itself
    assign overrun = ovr_reg || !keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ovr_reg <= ovr_next;
        end
    end

    property p_cnt_bound;
        @(posedge clk) disable iff (!rst_n) cnt_reg <= count_t'(MAX_LEN);
    endproperty
    a_cnt_bound: assert property (p_cnt_bound) else $error("count past capacity");

    property p_final_clears;
        @(posedge clk) disable iff (!rst_n) (q_push && is_final) |=> (cnt_reg == '0);
    endproperty
    a_final_clears: assert property (p_final_clears) else $error("count not cleared");

    property p_drop_sets;
        @(posedge clk) disable iff (!rst_n)
            (q_push && !keep && !is_final) |=> ovr_reg;
    endproperty
    a_drop_sets: assert property (p_drop_sets) else $error("overrun not set");

endmodule

FILE: sv/nwh_queue.sv
module nwh_queue
    import nwh_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  qword_t wdata,
    input  logic   ovr_in,
    input  logic   pop,
    output logic   empty,
    output logic   full,
    output qword_t rdata,
    output logic   ovr_out
);

    qword_t        mem_reg [QDEPTH];
    logic          ovm_reg [QDEPTH];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0]   n_reg;

    assign empty   = (n_reg == '0);
    assign full    = (n_reg == (QAW+1)'(QDEPTH));
    assign rdata   = mem_reg[rp_reg];
    assign ovr_out = ovm_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wdata;
            ovm_reg[wp_reg] <= ovr_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            n_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            n_reg <= n_reg + (QAW+1)'(push) - (QAW+1)'(pop);
        end
    end

    property p_no_overflow;
        @(posedge clk) disable iff (!rst_n) full |-> !push;
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

    property p_no_underflow;
        @(posedge clk) disable iff (!rst_n) empty |-> !pop;
    endproperty
    a_no_underflow: assert property (p_no_underflow) else $error("queue underflow");

endmodule

FILE: sv/nwh_back.sv
module nwh_back
    import nwh_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  qword_t  q_word,
    input  logic    q_ovr,
    output logic    q_pop,
    output logic    valid,
    output sample_t sample_out,
    output logic    end_of_vector,
    output logic [6:0] rotated_length,
    output logic    overrun
);

    sample_t     store [MAX_LEN];
    back_state_t st_reg, st_next;
    count_t      cnt_reg, cnt_next;
    count_t      p_reg, p_next;
    count_t      half_reg, half_next;
    count_t      j_reg, j_next;
    count_t      k_reg, k_next;
    logic        ovr_reg, ovr_next;
    sample_t     a_reg, rd_reg;
    logic signed [32:0] sum_reg, dif_reg;
    sample_t     sa, sd;

    addr_t ia, ib, raddr;
    logic  load_wr, last_bfly;

    // j counts butterflies; insert a zero at the half bit to get the low index
    always_comb
    begin
        count_t lowmask;
        count_t jj;
        lowmask = half_reg - count_t'(1);
        jj = ((j_reg & ~lowmask) << 1) | (j_reg & lowmask);
        ia = jj[AW-1:0];
        ib = ia + half_reg[AW-1:0];
    end

    function automatic sample_t scale(input logic signed [32:0] s);
        logic        neg;
        logic [32:0] mag;
        logic [63:0] q;
        neg = s[32];
        mag = neg ? 33'(-s) : 33'(s);
        q = (64'(mag) * 64'(STAGE_K) + (64'd1 << (STAGE_SHIFT-1))) >> STAGE_SHIFT;
        if (neg)
        begin
            scale = (q >= 64'h8000_0000) ? sample_t'(32'h8000_0000) : sample_t'(-q[31:0]);
        end
        else
        begin
            scale = (q > 64'h7FFF_FFFF) ? sample_t'(32'h7FFF_FFFF) : sample_t'(q[31:0]);
        end
    endfunction

    assign sa = scale(sum_reg);
    assign sd = scale(dif_reg);
    assign load_wr = (st_reg == ST_LOAD) && !q_empty && q_word.keep;
    assign last_bfly = (j_reg == (p_reg >> 1) - count_t'(1));

    // one read port: low operand, then high operand, else the output index
    assign raddr = (st_reg == ST_RD_A) ? ia :
                   (st_reg == ST_RD_B) ? ib : k_reg[AW-1:0];

    always_comb
    begin
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        p_next    = p_reg;
        half_next = half_reg;
        j_next    = j_reg;
        k_next    = k_reg;
        ovr_next  = ovr_reg;
        case (st_reg)
            ST_LOAD:
            begin
                if (!q_empty)
                begin
                    if (q_word.keep)
                    begin
                        cnt_next = cnt_reg + count_t'(1);
                    end
                    if (q_word.is_final)
                    begin
                        ovr_next  = q_ovr;
                        p_next    = pow2_below(q_word.keep ? cnt_reg + count_t'(1) : cnt_reg);
                        half_next = p_next >> 1;
                        j_next    = '0;
                        k_next    = '0;
                        st_next   = (p_next > count_t'(1)) ? ST_RD_A : ST_OUT;
                    end
                end
            end
            ST_RD_A: st_next = ST_RD_B;
            ST_RD_B: st_next = ST_MUL;
            ST_MUL:  st_next = ST_WR;
            ST_WR:
            begin
                st_next = ST_RD_A;
                if (last_bfly)
                begin
                    j_next = '0;
                    if (half_reg == count_t'(1))
                    begin
                        st_next = ST_OUT;
                    end
                    else
                    begin
                        half_next = half_reg >> 1;
                    end
                end
                else
                begin
                    j_next = j_reg + count_t'(1);
                end
            end
            ST_OUT:
            begin
                k_next = k_reg + count_t'(1);
                if (k_reg == cnt_reg - count_t'(1))
                begin
                    cnt_next = '0;
                    st_next  = ST_LOAD;
                end
            end
            default: st_next = ST_LOAD;
        endcase
    end

    assign q_pop = (st_reg == ST_LOAD) && !q_empty;

    always_ff @(posedge clk)
    begin
        case (st_reg)
            ST_LOAD:
            begin
                if (load_wr)
                begin
                    store[cnt_reg[AW-1:0]] <= q_word.sample;
                end
            end
            ST_RD_B: a_reg <= rd_reg;
            ST_WR:
            begin
                store[ia] <= sa;
                store[ib] <= sd;
            end
            default: ;
        endcase
        rd_reg <= store[raddr];
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= 33'(a_reg) + 33'(rd_reg);
        dif_reg <= 33'(a_reg) - 33'(rd_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_LOAD;
            cnt_reg  <= '0;
            p_reg    <= count_t'(1);
            half_reg <= count_t'(1);
            j_reg    <= '0;
            k_reg    <= '0;
            ovr_reg  <= 1'b0;
            valid    <= 1'b0;
            end_of_vector <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            p_reg    <= p_next;
            half_reg <= half_next;
            j_reg    <= j_next;
            k_reg    <= k_next;
            ovr_reg  <= ovr_next;
            valid    <= (st_reg == ST_OUT);
            end_of_vector <= (st_reg == ST_OUT) && (k_reg == cnt_reg - count_t'(1));
        end
    end

    assign sample_out     = rd_reg;
    assign rotated_length = 7'(p_reg);
    assign overrun        = ovr_reg;

    property p_out_len;
        @(posedge clk) disable iff (!rst_n) (st_reg == ST_OUT) |-> (k_reg < cnt_reg);
    endproperty
    a_out_len: assert property (p_out_len) else $error("read past count");

    property p_idx;
        @(posedge clk) disable iff (!rst_n)
            (st_reg == ST_RD_A) |-> (count_t'(ib) < p_reg);
    endproperty
    a_idx: assert property (p_idx) else $error("butterfly index beyond P");

    property p_pop_load;
        @(posedge clk) disable iff (!rst_n) q_pop |-> (st_reg == ST_LOAD);
    endproperty
    a_pop_load: assert property (p_pop_load) else $error("pop outside load");

endmodule
